FILE: rtl/clt_pkg.sv
// Shared types, character codes and helpers for the command-line tokenizer.
// Used by clt_step and command_line_tokenizer; depends on nothing.
package clt_pkg;

   localparam int unsigned MAX_ARGS = 256;
   localparam int unsigned RES_MAX  = 4;
   localparam logic [7:0]  COUNT_CAP =
      ((MAX_ARGS - 1) > 255) ? 8'd255 : 8'(MAX_ARGS - 1);

   localparam logic [15:0] CH_NUL       = 16'h0000;
   localparam logic [15:0] CH_TAB       = 16'h0009;
   localparam logic [15:0] CH_LF        = 16'h000A;
   localparam logic [15:0] CH_SPACE     = 16'h0020;
   localparam logic [15:0] CH_QUOTE     = 16'h0022;
   localparam logic [15:0] CH_ZERO      = 16'h0030;
   localparam logic [15:0] CH_BACKSLASH = 16'h005C;
   localparam logic [15:0] CH_LOWER_N   = 16'h006E;
   localparam logic [15:0] CH_LOWER_T   = 16'h0074;
   localparam logic [15:0] CH_LOWER_X   = 16'h0078;

   typedef enum logic [1:0] {
      KIND_CHAR     = 2'd0,
      KIND_ARG_END  = 2'd1,
      KIND_LINE_END = 2'd2
   } kind_type;

   typedef struct packed {
      logic        in_quotes;
      logic        escape_pending;
      logic        hex_pending;
      logic [15:0] hex_accum;
      logic        arg_nonempty;
      logic        prev_was_quote;
      logic [7:0]  arg_count;
   } parse_state_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] ch;
      logic [7:0]  arg_index;
   } result_type;

   typedef result_type burst_type [RES_MAX];

   // Returns {valid, value} for an ASCII hex digit.
   function automatic logic [4:0] hex_digit(input logic [15:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 16'h0030 && c <= 16'h0039) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 16'h0061 && c <= 16'h0066) || (c >= 16'h0041 && c <= 16'h0046)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage

FILE: rtl/command_line_tokenizer.sv
// Top level of the streaming command-line tokenizer: input register, parser state,
// and a four-entry result burst register. Depends on clt_pkg and clt_step.
//
//   channel   ports                               direction  moves
//   req       req_valid/ready, req_ch, req_last   in         one character
//   rsp       rsp_valid/ready, rsp_kind,          out        one token result
//             rsp_out_ch, rsp_arg_index
//
// An item is held in the input register, then its results (zero to four) are loaded
// into the burst register and leave one per cycle while rsp_ready is high; the first
// is offered once the item has passed the input register and the burst register.
// Sustained rate is one item per cycle while each item yields at most one result
// and rsp_ready stays high; an item yielding more results holds the input until
// the single result port has drained the burst register.
// Reset is synchronous and clears the parser state and all valid flags.
module command_line_tokenizer
   import clt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_ch,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_out_ch,
   output logic [7:0]  rsp_arg_index
);

   logic            in_valid_ff;
   logic [15:0]     in_ch_ff;
   logic            in_last_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   burst_type       burst_ff;
   burst_type       burst_in;
   logic [2:0]      burst_cnt_ff;
   logic [2:0]      burst_cnt_in;
   burst_type       step_results;
   logic [2:0]      step_count;
   logic            take;
   logic            burst_free;
   logic            advance;

   clt_step u_step (
      .state      (state_ff),
      .ch         (in_ch_ff),
      .last       (in_last_ff),
      .state_next (state_in),
      .results    (step_results),
      .count      (step_count)
   );

   assign rsp_valid     = (burst_cnt_ff != 3'd0);
   assign rsp_kind      = burst_ff[0].kind;
   assign rsp_out_ch    = burst_ff[0].ch;
   assign rsp_arg_index = burst_ff[0].arg_index;

   assign take       = rsp_valid && rsp_ready;
   assign burst_free = (burst_cnt_ff == 3'd0) || ((burst_cnt_ff == 3'd1) && rsp_ready);
   assign advance    = in_valid_ff && burst_free;
   assign req_ready  = !in_valid_ff || advance;

   always_comb begin
      burst_in     = burst_ff;
      burst_cnt_in = burst_cnt_ff;
      if (advance) begin
         burst_in     = step_results;
         burst_cnt_in = step_count;
      end else if (take) begin
         for (int i = 0; i < RES_MAX - 1; i++) begin
            burst_in[i] = burst_ff[i + 1];
         end
         burst_cnt_in = burst_cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= '0;
         burst_cnt_ff <= 3'd0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            state_ff <= state_in;
         end
         burst_cnt_ff <= burst_cnt_in;
      end
      if (req_valid && req_ready) begin
         in_ch_ff   <= req_ch;
         in_last_ff <= req_last;
      end
      burst_ff <= burst_in;
   end

endmodule

FILE: rtl/clt_step.sv
// Combinational parse of one character: next parser state and up to four results.
// Depends on clt_pkg.
module clt_step
   import clt_pkg::*;
(
   input  parse_state_type state,
   input  logic [15:0]     ch,
   input  logic            last,
   output parse_state_type state_next,
   output burst_type       results,
   output logic [2:0]      count
);

   always_comb begin
      parse_state_type s;
      burst_type       r;
      logic [2:0]      n;
      logic [4:0]      hd;
      logic            consumed;
      logic [15:0]     mapped;
      logic            is_sep;

      s        = state;
      n        = 3'd0;
      consumed = 1'b0;
      mapped   = ch;
      hd       = hex_digit(ch);
      is_sep   = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_NUL);
      for (int i = 0; i < RES_MAX; i++) begin
         r[i] = '{kind: KIND_CHAR, ch: 16'd0, arg_index: 8'd0};
      end

      if (s.escape_pending) begin
         s.escape_pending = 1'b0;
         if (ch == CH_LOWER_X) begin
            s.hex_pending = 1'b1;
         end else begin
            if (ch == CH_LOWER_N) begin
               mapped = CH_LF;
            end else if (ch == CH_LOWER_T) begin
               mapped = CH_TAB;
            end else if (ch == CH_ZERO) begin
               mapped = CH_NUL;
            end
            r[n[1:0]] = '{kind: KIND_CHAR, ch: mapped, arg_index: s.arg_count};
            n = n + 3'd1;
            s.arg_nonempty = 1'b1;
         end
         s.prev_was_quote = (ch == CH_QUOTE);
      end else begin
         if (s.hex_pending) begin
            if (hd[4]) begin
               s.hex_accum = {s.hex_accum[11:0], hd[3:0]};
               s.prev_was_quote = 1'b0;
               consumed = 1'b1;
            end else begin
               r[n[1:0]] = '{kind: KIND_CHAR, ch: s.hex_accum, arg_index: s.arg_count};
               n = n + 3'd1;
               s.arg_nonempty = 1'b1;
               s.hex_accum = 16'd0;
               s.hex_pending = 1'b0;
            end
         end
         if (!consumed) begin
            if (is_sep && !s.in_quotes) begin
               if (s.arg_nonempty || s.prev_was_quote) begin
                  r[n[1:0]] = '{kind: KIND_ARG_END, ch: 16'd0, arg_index: s.arg_count};
                  n = n + 3'd1;
                  if (s.arg_count < COUNT_CAP) begin
                     s.arg_count = s.arg_count + 8'd1;
                  end
                  s.arg_nonempty = 1'b0;
               end
            end else if (ch == CH_QUOTE) begin
               s.in_quotes = !s.in_quotes;
            end else if (ch == CH_BACKSLASH && s.in_quotes) begin
               s.escape_pending = 1'b1;
            end else begin
               r[n[1:0]] = '{kind: KIND_CHAR, ch: ch, arg_index: s.arg_count};
               n = n + 3'd1;
               s.arg_nonempty = 1'b1;
            end
            s.prev_was_quote = (ch == CH_QUOTE);
         end
      end

      if (last) begin
         if (s.hex_pending) begin
            r[n[1:0]] = '{kind: KIND_CHAR, ch: s.hex_accum, arg_index: s.arg_count};
            n = n + 3'd1;
            s.arg_nonempty = 1'b1;
         end
         if (s.arg_nonempty || s.prev_was_quote) begin
            r[n[1:0]] = '{kind: KIND_ARG_END, ch: 16'd0, arg_index: s.arg_count};
            n = n + 3'd1;
            if (s.arg_count < COUNT_CAP) begin
               s.arg_count = s.arg_count + 8'd1;
            end
         end
         r[n[1:0]] = '{kind: KIND_LINE_END, ch: 16'd0, arg_index: s.arg_count};
         n = n + 3'd1;
         s = '0;
      end

      state_next = s;
      results    = r;
      count      = n;
   end

endmodule
